// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// Each macro takes a label, a clock, an active-low reset and the property terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/kvfd_pkg.sv =====
package kvfd_pkg;

    localparam int COUNT_BITS = 16;

    localparam logic [63:0] TALLY_FULL  = (64'd1 << COUNT_BITS) - 64'd1;
    localparam logic [15:0] TALLY_LIMIT = (TALLY_FULL > 64'h0000_0000_0000_FFFF) ?
                                          16'hFFFF : TALLY_FULL[15:0];

    localparam int TDATA_BITS = 144;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_KLEN   = 3'd1,
        PH_VLEN   = 3'd2,
        PH_KEY    = 3'd3,
        PH_VALUE  = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ROLE_ID     = 3'd0,
        ROLE_STATUS = 3'd1,
        ROLE_KLEN   = 3'd2,
        ROLE_VLEN   = 3'd3,
        ROLE_KEY    = 3'd4,
        ROLE_VALUE  = 3'd5
    } t_role;

    typedef enum logic [2:0] {
        RES_OK         = 3'd0,
        RES_SHORT_HDR  = 3'd1,
        RES_CUT_DESC   = 3'd2,
        RES_CUT_KEY    = 3'd3,
        RES_CUT_VALUE  = 3'd4
    } t_result;

endpackage

// ===== src/kv_frame_deframer.sv =====
// Each accepted input beat gives its result beat on the output in the next cycle.
// Throughput: one byte per cycle; the output register frees itself in the same
// cycle that its beat is taken, so the parser stalls only while the output stalls.
// Reset (synchronous, active low) empties the output register and returns the
// parser to the header of a new frame; it also does so after every end-of-frame beat.
`include "assert_macros.svh"

module kv_frame_deframer
    import kvfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // frame_byte [7:0]
    input  logic [7:0]            s_axis_tdata,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // byte_out [7:0], request_number [39:8], status_byte [47:40], key_length [55:48],
    // value_length [119:56], records_done [135:120], frame_result [138:136], zeros above
    output logic [TDATA_BITS-1:0] m_axis_tdata,
    // byte_role [2:0]
    output logic [2:0]            m_axis_tuser,
    output logic                  m_axis_tlast
);

    t_phase      r_phase,    n_phase;
    logic [3:0]  r_pos,      n_pos;
    logic [31:0] r_id,       n_id;
    logic [7:0]  r_status,   n_status;
    logic [7:0]  r_klen,     n_klen;
    logic [63:0] r_vlen,     n_vlen;
    logic [63:0] r_left,     n_left;
    logic [15:0] r_tally,    n_tally;

    logic                  r_out_valid;
    logic [TDATA_BITS-1:0] r_out_data;
    t_role                 r_out_role;
    logic                  r_out_last;

    t_role       role;
    t_result     result;
    logic        accept;
    logic [3:0]  pos_inc;
    logic [63:0] left_dec;
    logic [15:0] tally_inc;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign pos_inc   = r_pos + 4'd1;
    assign left_dec  = r_left - 64'd1;
    assign tally_inc = (r_tally < TALLY_LIMIT) ? (r_tally + 16'd1) : r_tally;

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_id     = r_id;
        n_status = r_status;
        n_klen   = r_klen;
        n_vlen   = r_vlen;
        n_left   = r_left;
        n_tally  = r_tally;
        role     = ROLE_ID;
        unique case (r_phase)
            PH_KLEN: begin
                role    = ROLE_KLEN;
                n_klen  = s_axis_tdata;
                n_vlen  = '0;
                n_pos   = '0;
                n_phase = PH_VLEN;
            end
            PH_VLEN: begin
                role   = ROLE_VLEN;
                n_vlen = {r_vlen[55:0], s_axis_tdata};
                n_pos  = pos_inc;
                if (pos_inc >= 4'd8) begin
                    n_pos = '0;
                    if (r_klen != 8'd0) begin
                        n_left  = {56'd0, r_klen};
                        n_phase = PH_KEY;
                    end else if (n_vlen != 64'd0) begin
                        n_left  = n_vlen;
                        n_phase = PH_VALUE;
                    end else begin
                        n_tally = tally_inc;
                        n_phase = PH_KLEN;
                    end
                end
            end
            PH_KEY: begin
                role   = ROLE_KEY;
                n_left = left_dec;
                if (left_dec == 64'd0) begin
                    if (r_vlen != 64'd0) begin
                        n_left  = r_vlen;
                        n_phase = PH_VALUE;
                    end else begin
                        n_tally = tally_inc;
                        n_phase = PH_KLEN;
                    end
                end
            end
            PH_VALUE: begin
                role   = ROLE_VALUE;
                n_left = left_dec;
                if (left_dec == 64'd0) begin
                    n_tally = tally_inc;
                    n_phase = PH_KLEN;
                end
            end
            default: begin
                if (r_pos < 4'd4) begin
                    role  = ROLE_ID;
                    n_id  = {r_id[23:0], s_axis_tdata};
                    n_pos = pos_inc;
                end else begin
                    role     = ROLE_STATUS;
                    n_status = s_axis_tdata;
                    n_pos    = '0;
                    n_phase  = PH_KLEN;
                end
            end
        endcase

        result = RES_OK;
        if (s_axis_tlast) begin
            unique case (n_phase)
                PH_VLEN:  result = RES_CUT_DESC;
                PH_KEY:   result = RES_CUT_KEY;
                PH_VALUE: result = RES_CUT_VALUE;
                PH_KLEN:  result = RES_OK;
                default:  result = RES_SHORT_HDR;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_pos    <= '0;
            r_id     <= '0;
            r_status <= '0;
            r_klen   <= '0;
            r_vlen   <= '0;
            r_left   <= '0;
            r_tally  <= '0;
        end else if (accept) begin
            if (s_axis_tlast) begin
                r_phase  <= PH_HEADER;
                r_pos    <= '0;
                r_id     <= '0;
                r_status <= '0;
                r_klen   <= '0;
                r_vlen   <= '0;
                r_left   <= '0;
                r_tally  <= '0;
            end else begin
                r_phase  <= n_phase;
                r_pos    <= n_pos;
                r_id     <= n_id;
                r_status <= n_status;
                r_klen   <= n_klen;
                r_vlen   <= n_vlen;
                r_left   <= n_left;
                r_tally  <= n_tally;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {5'd0, result, n_tally, n_vlen, n_klen, n_status, n_id,
                           s_axis_tdata};
            r_out_role <= role;
            r_out_last <= s_axis_tlast;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_role;
    assign m_axis_tlast  = r_out_last;

    `ASSERT_IMPLY(a_result_only_at_end, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tlast, m_axis_tdata[138:136] == RES_OK)
    `ASSERT_NEXT(a_end_restarts_frame, i_clk, i_rst_n,
        accept && s_axis_tlast, r_phase == PH_HEADER && r_pos == 4'd0 && r_tally == 16'd0)
    `ASSERT_IMPLY(a_body_has_bytes_left, i_clk, i_rst_n,
        r_phase == PH_KEY || r_phase == PH_VALUE, r_left != 64'd0)
    `ASSERT_IMPLY(a_tally_in_limit, i_clk, i_rst_n, 1'b1, r_tally <= TALLY_LIMIT)

endmodule
